// File: src/stereo_snr_direction_detector_assert.svh
// Assertion macros for the stereo SNR direction detector.
// Expects clk_i and rst_ni in the scope of use.
`ifndef STEREO_SNR_DIRECTION_DETECTOR_ASSERT_SVH
`define STEREO_SNR_DIRECTION_DETECTOR_ASSERT_SVH

`define SSD_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ssd_pkg.sv
// Shared types, codes and defaults of the stereo SNR direction detector.
// No dependencies.
package ssd_pkg;

  localparam int SIGNAL_WINDOW   = 12;
  localparam int NOISE_WINDOW    = 64;
  localparam int MAX_FRAME_PAIRS = 256;
  localparam int LEVEL_DIVISOR   = 8;

  localparam int DATA_W    = 16;
  localparam int SNR_W     = 24;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DEN_W     = 16;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;

  localparam logic KIND_SUMMARY  = 1'b0;
  localparam logic KIND_DECISION = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MID_CODE   = 3'd0,
    CFG_SOUND_THR  = 3'd1,
    CFG_SNR_THR    = 3'd2,
    CFG_FREEZE_THR = 3'd3,
    CFG_RATIO_THR  = 3'd4,
    CFG_HOLDOFF    = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_ML, OP_MR, OP_AL, OP_AR, OP_NL, OP_FRL, OP_NR, OP_FRR,
    OP_FLL, OP_FLR, OP_SNL, OP_SNR, OP_SML, OP_SMR
  } div_op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_SIG_PUSH,
    ST_NOISE_RD, ST_NOISE_PUSH, ST_DECIDE, ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic    acc;
    logic    latch_dec;
    logic    frame_start;
    logic    div_go;
    logic    div_load;
    div_op_e op;
    logic    sig_push;
    logic    noise_rd;
    logic    noise_push;
    logic    decide;
    logic    emit;
    logic    kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic noise_empty;
    logic noise_push_ok;
    logic emit_ok;
  } dp_stat_t;

endpackage

// File: src/ssd_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; operands must hold until done.
module ssd_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(shifted - {1'b0, den_i}) : shifted[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: src/ssd_ctrl.sv
// Sequencer of the detector: sample accept, frame close steps, decision.
// Depends on ssd_pkg.
module ssd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              mode_i,
  input  logic              frame_end_i,
  input  ssd_pkg::dp_stat_t stat_i,
  output ssd_pkg::ctrl_cmd_t cmd_o,
  output logic              in_stall_o
);

  ssd_pkg::ctrl_state_e state_q, state_d;
  ssd_pkg::div_op_e     op_q, op_d;
  logic                 kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssd_pkg::ST_IDLE;
      op_q    <= ssd_pkg::OP_ML;
      kind_q  <= ssd_pkg::KIND_SUMMARY;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.op   = op_q;
    cmd_o.kind = kind_q;
    unique case (state_q)
      ssd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (mode_i) begin
            cmd_o.latch_dec = 1'b1;
            kind_d  = ssd_pkg::KIND_DECISION;
            state_d = ssd_pkg::ST_DECIDE;
          end else begin
            cmd_o.acc = 1'b1;
            if (frame_end_i) begin
              cmd_o.frame_start = 1'b1;
              kind_d  = ssd_pkg::KIND_SUMMARY;
              op_d    = ssd_pkg::OP_ML;
              state_d = ssd_pkg::ST_DIV_GO;
            end
          end
        end
      end
      ssd_pkg::ST_DIV_GO: begin
        cmd_o.div_go = 1'b1;
        state_d = ssd_pkg::ST_DIV_WAIT;
      end
      ssd_pkg::ST_DIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.div_load = 1'b1;
          state_d = ssd_pkg::ST_DIV_GO;
          unique case (op_q)
            ssd_pkg::OP_ML:  op_d = ssd_pkg::OP_MR;
            ssd_pkg::OP_MR:  state_d = ssd_pkg::ST_SIG_PUSH;
            ssd_pkg::OP_AL:  op_d = ssd_pkg::OP_AR;
            ssd_pkg::OP_AR: begin
              if (stat_i.noise_empty) state_d = ssd_pkg::ST_NOISE_RD;
              else op_d = ssd_pkg::OP_NL;
            end
            ssd_pkg::OP_NL:  op_d = ssd_pkg::OP_FRL;
            ssd_pkg::OP_FRL: op_d = ssd_pkg::OP_NR;
            ssd_pkg::OP_NR:  op_d = ssd_pkg::OP_FRR;
            ssd_pkg::OP_FRR: state_d = ssd_pkg::ST_NOISE_RD;
            ssd_pkg::OP_FLL: op_d = ssd_pkg::OP_FLR;
            ssd_pkg::OP_FLR: op_d = ssd_pkg::OP_SNL;
            ssd_pkg::OP_SNL: op_d = ssd_pkg::OP_SNR;
            ssd_pkg::OP_SNR: op_d = ssd_pkg::OP_SML;
            ssd_pkg::OP_SML: op_d = ssd_pkg::OP_SMR;
            ssd_pkg::OP_SMR: state_d = ssd_pkg::ST_EMIT;
            default:         state_d = ssd_pkg::ST_EMIT;
          endcase
        end
      end
      ssd_pkg::ST_SIG_PUSH: begin
        cmd_o.sig_push = 1'b1;
        op_d    = ssd_pkg::OP_AL;
        state_d = ssd_pkg::ST_DIV_GO;
      end
      ssd_pkg::ST_NOISE_RD: begin
        cmd_o.noise_rd = 1'b1;
        if (stat_i.noise_push_ok) begin
          state_d = ssd_pkg::ST_NOISE_PUSH;
        end else begin
          op_d    = ssd_pkg::OP_FLL;
          state_d = ssd_pkg::ST_DIV_GO;
        end
      end
      ssd_pkg::ST_NOISE_PUSH: begin
        cmd_o.noise_push = 1'b1;
        op_d    = ssd_pkg::OP_FLL;
        state_d = ssd_pkg::ST_DIV_GO;
      end
      ssd_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = ssd_pkg::ST_EMIT;
      end
      ssd_pkg::ST_EMIT: begin
        if (stat_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          state_d = ssd_pkg::ST_IDLE;
        end
      end
      default: state_d = ssd_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ssd_pkg::ST_IDLE);

endmodule

// File: src/ssd_dp.sv
// Datapath: frame accumulators, signal and noise windows, divider operands,
// gates and the result register. Depends on ssd_pkg, ssd_div and the macros.
`include "stereo_snr_direction_detector_assert.svh"
module ssd_dp #(
  parameter int SW  = ssd_pkg::SIGNAL_WINDOW,
  parameter int NW  = ssd_pkg::NOISE_WINDOW,
  parameter int MFP = ssd_pkg::MAX_FRAME_PAIRS,
  parameter int LD  = ssd_pkg::LEVEL_DIVISOR
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssd_pkg::ctrl_cmd_t             cmd_i,
  output ssd_pkg::dp_stat_t              stat_o,
  input  logic                           cfg_we_i,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssd_pkg::DATA_W-1:0]     cfg_data_i,
  input  logic [ssd_pkg::DATA_W-1:0]     left_sample_i,
  input  logic [ssd_pkg::DATA_W-1:0]     right_sample_i,
  input  logic [ssd_pkg::TIME_W-1:0]     now_ms_i,
  input  logic [ssd_pkg::TIME_W-1:0]     lock_until_ms_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic                           result_kind_o,
  output logic [1:0]                     direction_o,
  output logic [ssd_pkg::DATA_W-1:0]     level_left_o,
  output logic [ssd_pkg::DATA_W-1:0]     level_right_o,
  output logic [ssd_pkg::DATA_W-1:0]     noise_left_o,
  output logic [ssd_pkg::DATA_W-1:0]     noise_right_o,
  output logic [ssd_pkg::SNR_W-1:0]      snr_left_q8_o,
  output logic [ssd_pkg::SNR_W-1:0]      snr_right_q8_o,
  output logic [ssd_pkg::DATA_W-1:0]     peak_left_o,
  output logic [ssd_pkg::DATA_W-1:0]     peak_right_o,
  output logic                           noise_full_o,
  output logic [2:0]                     gate_flags_o
);

  localparam int DW      = ssd_pkg::DATA_W;
  localparam int TW      = ssd_pkg::TIME_W;
  localparam int DEN_W   = ssd_pkg::DEN_W;
  localparam int FCNT_W  = $clog2(MFP + 1);
  localparam int FSUM_W  = DW + $clog2(MFP);
  localparam int SFILL_W = $clog2(SW + 1);
  localparam int SIDX_W  = (SW > 1) ? $clog2(SW) : 1;
  localparam int SSUM_W  = DW + $clog2(SW);
  localparam int NFILL_W = $clog2(NW + 1);
  localparam int NIDX_W  = $clog2(NW);
  localparam int NSUM_W  = DW + $clog2(NW);
  localparam int Q8_W    = DW + 8;
  localparam int M1_W    = (FSUM_W > NSUM_W) ? FSUM_W : NSUM_W;
  localparam int M2_W    = (M1_W > SSUM_W) ? M1_W : SSUM_W;
  localparam int NUM_W   = (M2_W > Q8_W) ? M2_W : Q8_W;

  localparam logic [FCNT_W-1:0]  MFP_C  = FCNT_W'(MFP);
  localparam logic [SFILL_W-1:0] SW_C   = SFILL_W'(SW);
  localparam logic [SIDX_W-1:0]  SLAST  = SIDX_W'(SW - 1);
  localparam logic [NFILL_W-1:0] NW_C   = NFILL_W'(NW);
  localparam logic [NFILL_W-1:0] NQTR_C = NFILL_W'(NW / 4);
  localparam logic [NIDX_W-1:0]  NLAST  = NIDX_W'(NW - 1);
  localparam logic [DEN_W-1:0]   LD_C   = DEN_W'(LD);

  logic [DW-1:0] mid_q, sound_thr_q, snr_thr_q, freeze_thr_q, ratio_thr_q, holdoff_q;

  logic [FSUM_W-1:0]  fsum_l_q, fsum_r_q;
  logic [DW-1:0]      fpeak_l_q, fpeak_r_q;
  logic [FCNT_W-1:0]  fcnt_q;
  logic [2*DW-1:0]    shist_q [SW];
  logic [SIDX_W-1:0]  swi_q;
  logic [SFILL_W-1:0] sfill_q;
  logic [SSUM_W-1:0]  ssum_l_q, ssum_r_q;
  logic [2*DW-1:0]    nmem [NW];
  logic [2*DW-1:0]    nrd_q;
  logic [NIDX_W-1:0]  nwi_q;
  logic [NFILL_W-1:0] nfill_q;
  logic [NSUM_W-1:0]  nsum_l_q, nsum_r_q;
  logic [DW-1:0]      lvl_l_q, lvl_r_q, floor_l_q, floor_r_q;
  logic [ssd_pkg::SNR_W-1:0] snr_l_q, snr_r_q;
  logic [1:0]         dir_q;
  logic [TW-1:0]      last_q, now_q, lock_q;
  logic [DW-1:0]      ml_q, mr_q, al_q, ar_q, nl_q, nr_q;
  logic               freeze_q;
  logic [2:0]         gates_q;
  logic               out_valid_q;

  logic [DW-1:0]    dist_l, dist_r;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den, den_raw;
  logic             div_done;
  logic [DW-1:0]    q16;

  assign dist_l = (left_sample_i > mid_q) ? DW'(left_sample_i - mid_q)
                                          : DW'(mid_q - left_sample_i);
  assign dist_r = (right_sample_i > mid_q) ? DW'(right_sample_i - mid_q)
                                           : DW'(mid_q - right_sample_i);

  always_comb begin
    div_num = '0;
    den_raw = '0;
    case (cmd_i.op) inside
      ssd_pkg::OP_ML:  begin div_num = NUM_W'(fsum_l_q); den_raw = DEN_W'(fcnt_q); end
      ssd_pkg::OP_MR:  begin div_num = NUM_W'(fsum_r_q); den_raw = DEN_W'(fcnt_q); end
      ssd_pkg::OP_AL:  begin div_num = NUM_W'(ssum_l_q); den_raw = DEN_W'(sfill_q); end
      ssd_pkg::OP_AR:  begin div_num = NUM_W'(ssum_r_q); den_raw = DEN_W'(sfill_q); end
      ssd_pkg::OP_NL,
      ssd_pkg::OP_FLL: begin div_num = NUM_W'(nsum_l_q); den_raw = DEN_W'(nfill_q); end
      ssd_pkg::OP_NR,
      ssd_pkg::OP_FLR: begin div_num = NUM_W'(nsum_r_q); den_raw = DEN_W'(nfill_q); end
      ssd_pkg::OP_FRL: begin div_num = NUM_W'({ml_q, 8'd0}); den_raw = nl_q; end
      ssd_pkg::OP_FRR: begin div_num = NUM_W'({mr_q, 8'd0}); den_raw = nr_q; end
      ssd_pkg::OP_SNL: begin div_num = NUM_W'({al_q, 8'd0}); den_raw = floor_l_q; end
      ssd_pkg::OP_SNR: begin div_num = NUM_W'({ar_q, 8'd0}); den_raw = floor_r_q; end
      ssd_pkg::OP_SML: begin
        div_num = NUM_W'((al_q >= lvl_l_q) ? DW'(al_q - lvl_l_q) : DW'(lvl_l_q - al_q));
        den_raw = LD_C;
      end
      ssd_pkg::OP_SMR: begin
        div_num = NUM_W'((ar_q >= lvl_r_q) ? DW'(ar_q - lvl_r_q) : DW'(lvl_r_q - ar_q));
        den_raw = LD_C;
      end
      default: begin div_num = '0; den_raw = '0; end
    endcase
  end

  assign div_den = (den_raw == '0) ? DEN_W'(1) : den_raw;
  assign q16     = div_quo[DW-1:0];

  ssd_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_go),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  logic                 s_full, n_full;
  logic [DW-1:0]        s_old_l, s_old_r, n_old_l, n_old_r;
  logic [SIDX_W-1:0]    swi_next;
  logic [NIDX_W-1:0]    nwi_next;

  assign s_full   = (sfill_q == SW_C);
  assign n_full   = (nfill_q == NW_C);
  assign s_old_l  = s_full ? shist_q[swi_q][2*DW-1:DW] : '0;
  assign s_old_r  = s_full ? shist_q[swi_q][DW-1:0] : '0;
  assign n_old_l  = n_full ? nrd_q[2*DW-1:DW] : '0;
  assign n_old_r  = n_full ? nrd_q[DW-1:0] : '0;
  assign swi_next = (swi_q == SLAST) ? '0 : SIDX_W'(swi_q + SIDX_W'(1));
  assign nwi_next = (nwi_q == NLAST) ? '0 : NIDX_W'(nwi_q + NIDX_W'(1));

  logic [ssd_pkg::SNR_W-1:0] win, lose;
  logic [TW-1:0]             lock_diff, sw_diff;
  logic [ssd_pkg::SNR_W+DW-1:0] prod;
  logic g_sound, g_snr, g_ratio, take;
  logic [1:0] nd;

  assign win       = (snr_l_q > snr_r_q) ? snr_l_q : snr_r_q;
  assign lose      = (snr_l_q > snr_r_q) ? snr_r_q : snr_l_q;
  assign prod      = lose * ratio_thr_q;
  assign g_sound   = (lvl_l_q >= sound_thr_q) || (lvl_r_q >= sound_thr_q);
  assign g_snr     = (snr_l_q >= ssd_pkg::SNR_W'(snr_thr_q)) ||
                     (snr_r_q >= ssd_pkg::SNR_W'(snr_thr_q));
  assign g_ratio   = ({8'd0, win, 8'd0} >= prod);
  assign lock_diff = now_q - lock_q;
  assign sw_diff   = now_q - last_q;
  assign nd        = (snr_l_q > snr_r_q) ? ssd_pkg::DIR_LEFT : ssd_pkg::DIR_RIGHT;
  assign take      = !lock_diff[TW-1] && n_full && g_sound && g_snr && g_ratio &&
                     (nd != dir_q) && (sw_diff >= TW'(holdoff_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q        <= 16'd32768;
      sound_thr_q  <= 16'd390;
      snr_thr_q    <= 16'd384;
      freeze_thr_q <= 16'd320;
      ratio_thr_q  <= 16'd384;
      holdoff_q    <= 16'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssd_pkg::CFG_MID_CODE:   mid_q        <= cfg_data_i;
        ssd_pkg::CFG_SOUND_THR:  sound_thr_q  <= cfg_data_i;
        ssd_pkg::CFG_SNR_THR:    snr_thr_q    <= cfg_data_i;
        ssd_pkg::CFG_FREEZE_THR: freeze_thr_q <= cfg_data_i;
        ssd_pkg::CFG_RATIO_THR:  ratio_thr_q  <= cfg_data_i;
        ssd_pkg::CFG_HOLDOFF:    holdoff_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsum_l_q  <= '0;
      fsum_r_q  <= '0;
      fpeak_l_q <= '0;
      fpeak_r_q <= '0;
      fcnt_q    <= '0;
      swi_q     <= '0;
      sfill_q   <= '0;
      ssum_l_q  <= '0;
      ssum_r_q  <= '0;
      nwi_q     <= '0;
      nfill_q   <= '0;
      nsum_l_q  <= '0;
      nsum_r_q  <= '0;
      lvl_l_q   <= '0;
      lvl_r_q   <= '0;
      snr_l_q   <= '0;
      snr_r_q   <= '0;
      floor_l_q <= DW'(1);
      floor_r_q <= DW'(1);
      dir_q     <= ssd_pkg::DIR_NONE;
      last_q    <= '0;
      freeze_q  <= 1'b0;
      gates_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc && (fcnt_q < MFP_C)) begin
        fsum_l_q <= fsum_l_q + FSUM_W'(dist_l);
        fsum_r_q <= fsum_r_q + FSUM_W'(dist_r);
        if (dist_l > fpeak_l_q) fpeak_l_q <= dist_l;
        if (dist_r > fpeak_r_q) fpeak_r_q <= dist_r;
        fcnt_q <= fcnt_q + FCNT_W'(1);
      end
      if (cmd_i.frame_start) freeze_q <= 1'b0;
      if (cmd_i.div_load) begin
        case (cmd_i.op) inside
          ssd_pkg::OP_FRL,
          ssd_pkg::OP_FRR: if (div_quo >= NUM_W'(freeze_thr_q)) freeze_q <= 1'b1;
          ssd_pkg::OP_FLL: floor_l_q <= q16;
          ssd_pkg::OP_FLR: floor_r_q <= q16;
          ssd_pkg::OP_SNL: snr_l_q <= div_quo[ssd_pkg::SNR_W-1:0];
          ssd_pkg::OP_SNR: snr_r_q <= div_quo[ssd_pkg::SNR_W-1:0];
          ssd_pkg::OP_SML: lvl_l_q <= (al_q >= lvl_l_q) ? DW'(lvl_l_q + q16)
                                                        : DW'(lvl_l_q - q16);
          ssd_pkg::OP_SMR: lvl_r_q <= (ar_q >= lvl_r_q) ? DW'(lvl_r_q + q16)
                                                        : DW'(lvl_r_q - q16);
          default: ;
        endcase
      end
      if (cmd_i.sig_push) begin
        ssum_l_q <= SSUM_W'(ssum_l_q - SSUM_W'(s_old_l) + SSUM_W'(ml_q));
        ssum_r_q <= SSUM_W'(ssum_r_q - SSUM_W'(s_old_r) + SSUM_W'(mr_q));
        if (!s_full) sfill_q <= sfill_q + SFILL_W'(1);
        swi_q <= swi_next;
      end
      if (cmd_i.noise_push) begin
        nsum_l_q <= NSUM_W'(nsum_l_q - NSUM_W'(n_old_l) + NSUM_W'(ml_q));
        nsum_r_q <= NSUM_W'(nsum_r_q - NSUM_W'(n_old_r) + NSUM_W'(mr_q));
        if (!n_full) nfill_q <= nfill_q + NFILL_W'(1);
        nwi_q <= nwi_next;
      end
      if (cmd_i.decide) begin
        gates_q <= {g_ratio, g_snr, g_sound};
        if (take) begin
          dir_q  <= nd;
          last_q <= now_q;
        end
      end
      if (cmd_i.emit && (cmd_i.kind == ssd_pkg::KIND_SUMMARY)) begin
        fsum_l_q  <= '0;
        fsum_r_q  <= '0;
        fpeak_l_q <= '0;
        fpeak_r_q <= '0;
        fcnt_q    <= '0;
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      case (cmd_i.op)
        ssd_pkg::OP_ML: ml_q <= q16;
        ssd_pkg::OP_MR: mr_q <= q16;
        ssd_pkg::OP_AL: al_q <= q16;
        ssd_pkg::OP_AR: ar_q <= q16;
        ssd_pkg::OP_NL: nl_q <= q16;
        ssd_pkg::OP_NR: nr_q <= q16;
        default: ;
      endcase
    end
    if (cmd_i.latch_dec) begin
      now_q  <= now_ms_i;
      lock_q <= lock_until_ms_i;
    end
    if (cmd_i.sig_push) shist_q[swi_q] <= {ml_q, mr_q};
    if (cmd_i.noise_rd) nrd_q <= nmem[nwi_q];
    if (cmd_i.noise_push) nmem[nwi_q] <= {ml_q, mr_q};
    if (cmd_i.emit) begin
      result_kind_o  <= cmd_i.kind;
      direction_o    <= dir_q;
      level_left_o   <= lvl_l_q;
      level_right_o  <= lvl_r_q;
      noise_left_o   <= floor_l_q;
      noise_right_o  <= floor_r_q;
      snr_left_q8_o  <= snr_l_q;
      snr_right_q8_o <= snr_r_q;
      noise_full_o   <= n_full;
      if (cmd_i.kind == ssd_pkg::KIND_SUMMARY) begin
        peak_left_o  <= fpeak_l_q;
        peak_right_o <= fpeak_r_q;
        gate_flags_o <= '0;
      end else begin
        peak_left_o  <= '0;
        peak_right_o <= '0;
        gate_flags_o <= gates_q;
      end
    end
  end

  assign stat_o.div_done      = div_done;
  assign stat_o.noise_empty   = (nfill_q == '0);
  assign stat_o.noise_push_ok = !freeze_q || (nfill_q < NQTR_C);
  assign stat_o.emit_ok       = !out_valid_q || !out_stall_i;
  assign out_valid_o          = out_valid_q;

  `SSD_ASSERT_HOLDS(a_sfill_bound, sfill_q <= SW_C, "signal fill beyond window")
  `SSD_ASSERT_HOLDS(a_nfill_bound, nfill_q <= NW_C, "noise fill beyond window")
  `SSD_ASSERT_HOLDS(a_fcnt_bound, fcnt_q <= MFP_C, "frame count beyond limit")
  `SSD_ASSERT_NEXT(a_emit_valid, cmd_i.emit, out_valid_q, "emitted result not valid")

endmodule

// File: src/stereo_snr_direction_detector.sv
// Top level of the stereo SNR direction detector.
// Depends on ssd_pkg, ssd_ctrl and ssd_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid_i/in_stall_o| mode, samples, frame_end, now, lock
//  out     | out_valid_o/out_stall_i | kind, direction, levels, noise, snr,
//          |                      | peaks, noise_full, gate_flags
//  cfg     | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// A sample pair without frame end is taken in idle; a decision request runs
// decide, then emit. A frame end runs up to 14 divisions on one shared
// radix-2 divider, fewer with an empty noise window, plus window steps.
// Reset clears all control state and sets the register defaults.
// New requests are taken while a result waits at the output register.
module stereo_snr_direction_detector #(
  parameter int SIGNAL_WINDOW   = ssd_pkg::SIGNAL_WINDOW,
  parameter int NOISE_WINDOW    = ssd_pkg::NOISE_WINDOW,
  parameter int MAX_FRAME_PAIRS = ssd_pkg::MAX_FRAME_PAIRS,
  parameter int LEVEL_DIVISOR   = ssd_pkg::LEVEL_DIVISOR
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [ssd_pkg::DATA_W-1:0]    left_sample_i,
  input  logic [ssd_pkg::DATA_W-1:0]    right_sample_i,
  input  logic                          frame_end_i,
  input  logic [ssd_pkg::TIME_W-1:0]    now_ms_i,
  input  logic [ssd_pkg::TIME_W-1:0]    lock_until_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_kind_o,
  output logic [1:0]                    direction_o,
  output logic [ssd_pkg::DATA_W-1:0]    level_left_o,
  output logic [ssd_pkg::DATA_W-1:0]    level_right_o,
  output logic [ssd_pkg::DATA_W-1:0]    noise_left_o,
  output logic [ssd_pkg::DATA_W-1:0]    noise_right_o,
  output logic [ssd_pkg::SNR_W-1:0]     snr_left_q8_o,
  output logic [ssd_pkg::SNR_W-1:0]     snr_right_q8_o,
  output logic [ssd_pkg::DATA_W-1:0]    peak_left_o,
  output logic [ssd_pkg::DATA_W-1:0]    peak_right_o,
  output logic                          noise_full_o,
  output logic [2:0]                    gate_flags_o,
  input  logic                          cfg_we_i,
  input  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ssd_pkg::DATA_W-1:0]    cfg_data_i
);

  ssd_pkg::ctrl_cmd_t cmd;
  ssd_pkg::dp_stat_t  stat;

  ssd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .frame_end_i(frame_end_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  ssd_dp #(
    .SW (SIGNAL_WINDOW),
    .NW (NOISE_WINDOW),
    .MFP(MAX_FRAME_PAIRS),
    .LD (LEVEL_DIVISOR)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .now_ms_i       (now_ms_i),
    .lock_until_ms_i(lock_until_ms_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .result_kind_o  (result_kind_o),
    .direction_o    (direction_o),
    .level_left_o   (level_left_o),
    .level_right_o  (level_right_o),
    .noise_left_o   (noise_left_o),
    .noise_right_o  (noise_right_o),
    .snr_left_q8_o  (snr_left_q8_o),
    .snr_right_q8_o (snr_right_q8_o),
    .peak_left_o    (peak_left_o),
    .peak_right_o   (peak_right_o),
    .noise_full_o   (noise_full_o),
    .gate_flags_o   (gate_flags_o)
  );

endmodule
